### design/qbf_pkg.sv
// Package for the quartic bond force pipeline.
// Holds field widths, item kinds, saturation limits and the stage payload types.
// Used by design/quartic_bond_force.sv.
package qbf_pkg;

	localparam int R_W = 32;
	localparam int FW  = 48;
	localparam int EW  = 84;
	localparam int QB  = 48;

	localparam logic KIND_EVAL = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	localparam logic [FW-1:0] FORCE_POS_LIM = 48'h7FFF_FFFF_FFFF;
	localparam logic [FW-1:0] FORCE_NEG_LIM = 48'h8000_0000_0000;
	localparam logic [63:0]   ENERGY_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0]   ENERGY_MIN    = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [30:0] r0;
		logic [31:0] k2;
		logic [31:0] k3;
		logic [31:0] k4;
	} coef_raw_t;

	typedef struct packed {
		logic [30:0]      r0;
		logic [2:0]       ks;
		logic [2:0][31:0] km;
	} coef_t;

	typedef struct packed {
		logic [2:0]       neg;
		logic [2:0][31:0] mag;
		logic             want_e;
	} vec_t;

	typedef struct packed {
		logic [R_W-1:0] r;
		logic [2:0]     dneg;
		logic           deneg;
		logic [63:0]    energy;
		logic           esat;
	} late_t;

	typedef struct packed {
		logic [2:0][FW-1:0] force_v;
		logic [63:0]        energy;
		logic               sat;
	} res_t;

endpackage

### design/quartic_bond_force.sv
// Quartic bond force and energy pipeline, top level.
// Depends on qbf_pkg for widths, limits and stage payload types.
// A new item is taken every cycle unless stalled; each evaluate item passes through three
// input and squaring stages, 32 square root stages (one result bit each), twelve stages of
// polynomial and force products, 48 division stages (one quotient bit each) and the output
// register. A load item writes its coefficients at once and yields no result; the coefficient
// memory has a registered read, so an evaluate item may follow its load in the next cycle. An
// output register with one skid entry lets the pipeline keep accepting while one result waits;
// a second waiting result parks in the skid entry and stalls the input until the first leaves.
module quartic_bond_force #(
	parameter int NUM_TYPES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                kind,
	input  logic [3:0]          bond_type,
	input  logic signed [31:0]  delta_x,
	input  logic signed [31:0]  delta_y,
	input  logic signed [31:0]  delta_z,
	input  logic                want_energy,
	input  logic [30:0]         rest_length_in,
	input  logic signed [31:0]  quad_coeff_in,
	input  logic signed [31:0]  cubic_coeff_in,
	input  logic signed [31:0]  quartic_coeff_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [47:0]  force_x,
	output logic signed [47:0]  force_y,
	output logic signed [47:0]  force_z,
	output logic signed [63:0]  bond_energy,
	output logic                saturated
);

	localparam int IW   = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
	localparam int SQ_N = qbf_pkg::R_W;
	localparam int DV_N = qbf_pkg::QB;
	localparam int EW   = qbf_pkg::EW;

	logic en;
	logic out_v_q, skid_v_q;
	logic accept;
	logic [7:0] type_ext;
	logic [IW-1:0] idx;
	logic type_ok;
	qbf_pkg::vec_t vec_in;
	logic [2:0][31:0] din;

	qbf_pkg::coef_raw_t coef_mem_q [NUM_TYPES];

	assign en       = 1'b1 & ~skid_v_q;
	assign in_ready = en;
	assign accept   = in_valid & en;
	assign type_ext = {4'b0000, bond_type};
	assign idx      = type_ext[IW-1:0];
	assign type_ok  = {1'b0, type_ext} < 9'(NUM_TYPES);
	assign din      = {delta_z, delta_y, delta_x};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vec_in.neg[i] = din[i][31];
			vec_in.mag[i] = din[i][31] ? (~din[i] + 32'd1) : din[i];
		end
		vec_in.want_e = want_energy;
	end

	always_ff @(posedge clk) begin
		if (accept && kind == qbf_pkg::KIND_LOAD && type_ok) begin
			coef_mem_q[idx] <= '{r0: rest_length_in, k2: quad_coeff_in,
				k3: cubic_coeff_in, k4: quartic_coeff_in};
		end
	end

	// Stage 1: registered table read, magnitudes of the displacement.
	logic v_s1, tok_s1;
	qbf_pkg::vec_t vec_s1;
	qbf_pkg::coef_raw_t crd_s1;

	// Stage 2: squares and signed coefficients split into sign and magnitude.
	logic v_s2;
	qbf_pkg::vec_t vec_s2;
	qbf_pkg::coef_t coef_s2;
	logic [2:0][63:0] sq_s2;
	qbf_pkg::coef_t coef_n2;
	logic [2:0][31:0] kraw;

	// Stage 3: squared length.
	logic v_s3;
	qbf_pkg::vec_t vec_s3;
	qbf_pkg::coef_t coef_s3;
	logic [63:0] rsq_s3;

	assign kraw = {crd_s1.k4, crd_s1.k3, crd_s1.k2};

	always_comb begin
		coef_n2.r0 = tok_s1 ? crd_s1.r0 : 31'd0;
		for (int i = 0; i < 3; i++) begin
			coef_n2.ks[i] = tok_s1 & kraw[i][31];
			coef_n2.km[i] = !tok_s1 ? 32'd0 : (kraw[i][31] ? (~kraw[i] + 32'd1) : kraw[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1  <= vec_in;
			tok_s1  <= type_ok;
			crd_s1  <= coef_mem_q[idx];
			vec_s2  <= vec_s1;
			coef_s2 <= coef_n2;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= 64'(vec_s1.mag[i]) * 64'(vec_s1.mag[i]);
			end
			vec_s3  <= vec_s2;
			coef_s3 <= coef_s2;
			rsq_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		end
	end

	// Square root, one result bit per stage.
	logic        sr_v_s    [SQ_N];
	logic [33:0] sr_rem_s  [SQ_N];
	logic [31:0] sr_res_s  [SQ_N];
	logic [63:0] sr_rad_s  [SQ_N];
	qbf_pkg::vec_t  sr_vec_s  [SQ_N];
	qbf_pkg::coef_t sr_coef_s [SQ_N];

	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		logic        v_i;
		logic [33:0] rem_i;
		logic [31:0] res_i;
		logic [63:0] rad_i;
		qbf_pkg::vec_t  vec_i;
		qbf_pkg::coef_t coef_i;
		logic [35:0] cur, trial;

		if (k == 0) begin : g_first
			assign v_i    = v_s3;
			assign rem_i  = '0;
			assign res_i  = '0;
			assign rad_i  = rsq_s3;
			assign vec_i  = vec_s3;
			assign coef_i = coef_s3;
		end else begin : g_next
			assign v_i    = sr_v_s[k-1];
			assign rem_i  = sr_rem_s[k-1];
			assign res_i  = sr_res_s[k-1];
			assign rad_i  = sr_rad_s[k-1];
			assign vec_i  = sr_vec_s[k-1];
			assign coef_i = sr_coef_s[k-1];
		end

		assign cur   = {rem_i, rad_i[63:62]};
		assign trial = {2'b00, res_i, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sr_v_s[k] <= 1'b0;
			end else if (en) begin
				sr_v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (cur >= trial) begin
					sr_rem_s[k] <= 34'(cur - trial);
					sr_res_s[k] <= {res_i[30:0], 1'b1};
				end else begin
					sr_rem_s[k] <= cur[33:0];
					sr_res_s[k] <= {res_i[30:0], 1'b0};
				end
				sr_rad_s[k]  <= {rad_i[61:0], 2'b00};
				sr_vec_s[k]  <= vec_i;
				sr_coef_s[k] <= coef_i;
			end
		end
	end

	// Stages 4 to 15: stretch, its powers, dE/dr, energy and the force numerators.
	logic v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14, v_s15;

	logic signed [33:0] dr;
	logic [31:0] m_n4;
	logic [31:0] m_s4, m_s5, m_s6, m_s7;
	logic drneg_s4, drneg_s5, drneg_s6, drneg_s7, drneg_s8, drneg_s9;
	logic [31:0] r_s4, r_s5, r_s6, r_s7, r_s8, r_s9, r_s10, r_s11, r_s12, r_s13, r_s14;
	qbf_pkg::vec_t vec_s4, vec_s5, vec_s6, vec_s7, vec_s8, vec_s9, vec_s10, vec_s11, vec_s12;
	qbf_pkg::coef_t coef_s4, coef_s5, coef_s6, coef_s7, coef_s8, coef_s9, coef_s10, coef_s11;

	logic [63:0] mm_s5, k2m_s5, k2m_s6, k2m_s7, k2m_s8, k2m_s9;
	logic [39:0] p2;
	logic [39:0] pmh_s6, k3p2h_s6, k2p2h_s6;
	logic [63:0] pml_s6, k3p2l_s6, k2p2l_s6;
	logic [71:0] p3full, k3p2_s7, k2p2_s7, k3p2_s8, k2p2_s8, k3p2_s9, k2p2_s9;
	logic [47:0] p3_s7;
	logic [47:0] pmh_s8, k4p3h_s8, k3p3h_s8;
	logic [63:0] pml_s8, k4p3l_s8, k3p3l_s8;
	logic [79:0] p4full, k4p3_s9, k3p3_s9;
	logic [55:0] p4_s9;
	logic [55:0] k4p4h_s10;
	logic [63:0] k4p4l_s10;
	logic [87:0] k4p4_s11;

	logic [73:0] k3p2x3;
	logic [44:0] t2mag;
	logic [53:0] t3mag;
	logic [61:0] t4mag;
	logic [63:0] t2_s10, t3_s10, t4_s10;
	logic [EW-1:0] e2mag, e3mag, e4mag;
	logic [EW-1:0] e2_s10, e3_s10, e23_s11, esum_s12;
	logic [63:0] de_s11, demag_s12;
	logic deneg_s12;
	logic [2:0][63:0] fph_s13, fpl_s13;
	qbf_pkg::late_t late_n13, late_s13, late_s14, late_s15;
	logic [2:0][95:0] n_s14;
	logic [2:0] ovf_s15;
	logic [2:0][31:0] rem_s15;
	logic [2:0][47:0] lo_s15;

	assign dr     = $signed({2'b00, sr_res_s[SQ_N-1]}) - $signed({3'b000, sr_coef_s[SQ_N-1].r0});
	assign m_n4   = dr[33] ? 32'(-dr) : dr[31:0];
	assign p2     = mm_s5[63:24];
	assign p3full = {pmh_s6, 32'd0} + {8'd0, pml_s6};
	assign p4full = {pmh_s8, 32'd0} + {16'd0, pml_s8};

	assign k3p2x3 = {1'b0, k3p2_s9, 1'b0} + {2'b00, k3p2_s9};
	assign t2mag  = k2m_s9[63:19];
	assign t3mag  = k3p2x3[73:20];
	assign t4mag  = k4p3_s9[79:18];
	assign e2mag  = EW'(k2p2_s9[71:8]);
	assign e3mag  = EW'(k3p3_s9[79:8]);
	assign e4mag  = EW'(k4p4_s11[87:8]);

	always_comb begin
		late_n13.r     = r_s12;
		late_n13.dneg  = vec_s12.neg;
		late_n13.deneg = deneg_s12;
		if (!vec_s12.want_e) begin
			late_n13.energy = 64'd0;
			late_n13.esat   = 1'b0;
		end else if (esum_s12[EW-1:63] == {(EW-63){esum_s12[63]}}) begin
			late_n13.energy = esum_s12[63:0];
			late_n13.esat   = 1'b0;
		end else begin
			late_n13.energy = esum_s12[EW-1] ? qbf_pkg::ENERGY_MIN : qbf_pkg::ENERGY_MAX;
			late_n13.esat   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s4     <= m_n4;
			drneg_s4 <= dr[33];
			r_s4     <= sr_res_s[SQ_N-1];
			vec_s4   <= sr_vec_s[SQ_N-1];
			coef_s4  <= sr_coef_s[SQ_N-1];

			mm_s5    <= 64'(m_s4) * 64'(m_s4);
			k2m_s5   <= 64'(coef_s4.km[0]) * 64'(m_s4);
			m_s5     <= m_s4;
			drneg_s5 <= drneg_s4;
			r_s5     <= r_s4;
			vec_s5   <= vec_s4;
			coef_s5  <= coef_s4;

			pmh_s6   <= 40'(p2[39:32]) * 40'(m_s5);
			pml_s6   <= 64'(p2[31:0]) * 64'(m_s5);
			k3p2h_s6 <= 40'(p2[39:32]) * 40'(coef_s5.km[1]);
			k3p2l_s6 <= 64'(p2[31:0]) * 64'(coef_s5.km[1]);
			k2p2h_s6 <= 40'(p2[39:32]) * 40'(coef_s5.km[0]);
			k2p2l_s6 <= 64'(p2[31:0]) * 64'(coef_s5.km[0]);
			k2m_s6   <= k2m_s5;
			m_s6     <= m_s5;
			drneg_s6 <= drneg_s5;
			r_s6     <= r_s5;
			vec_s6   <= vec_s5;
			coef_s6  <= coef_s5;

			p3_s7    <= p3full[71:24];
			k3p2_s7  <= {k3p2h_s6, 32'd0} + {8'd0, k3p2l_s6};
			k2p2_s7  <= {k2p2h_s6, 32'd0} + {8'd0, k2p2l_s6};
			k2m_s7   <= k2m_s6;
			m_s7     <= m_s6;
			drneg_s7 <= drneg_s6;
			r_s7     <= r_s6;
			vec_s7   <= vec_s6;
			coef_s7  <= coef_s6;

			pmh_s8   <= 48'(p3_s7[47:32]) * 48'(m_s7);
			pml_s8   <= 64'(p3_s7[31:0]) * 64'(m_s7);
			k4p3h_s8 <= 48'(p3_s7[47:32]) * 48'(coef_s7.km[2]);
			k4p3l_s8 <= 64'(p3_s7[31:0]) * 64'(coef_s7.km[2]);
			k3p3h_s8 <= 48'(p3_s7[47:32]) * 48'(coef_s7.km[1]);
			k3p3l_s8 <= 64'(p3_s7[31:0]) * 64'(coef_s7.km[1]);
			k3p2_s8  <= k3p2_s7;
			k2p2_s8  <= k2p2_s7;
			k2m_s8   <= k2m_s7;
			drneg_s8 <= drneg_s7;
			r_s8     <= r_s7;
			vec_s8   <= vec_s7;
			coef_s8  <= coef_s7;

			p4_s9    <= p4full[79:24];
			k4p3_s9  <= {k4p3h_s8, 32'd0} + {16'd0, k4p3l_s8};
			k3p3_s9  <= {k3p3h_s8, 32'd0} + {16'd0, k3p3l_s8};
			k3p2_s9  <= k3p2_s8;
			k2p2_s9  <= k2p2_s8;
			k2m_s9   <= k2m_s8;
			drneg_s9 <= drneg_s8;
			r_s9     <= r_s8;
			vec_s9   <= vec_s8;
			coef_s9  <= coef_s8;

			k4p4h_s10 <= 56'(p4_s9[55:32]) * 56'(coef_s9.km[2]);
			k4p4l_s10 <= 64'(p4_s9[31:0]) * 64'(coef_s9.km[2]);
			t2_s10   <= (coef_s9.ks[0] ^ drneg_s9) ? 64'd0 - 64'(t2mag) : 64'(t2mag);
			t3_s10   <= coef_s9.ks[1] ? 64'd0 - 64'(t3mag) : 64'(t3mag);
			t4_s10   <= (coef_s9.ks[2] ^ drneg_s9) ? 64'd0 - 64'(t4mag) : 64'(t4mag);
			e2_s10   <= coef_s9.ks[0] ? '0 - e2mag : e2mag;
			e3_s10   <= (coef_s9.ks[1] ^ drneg_s9) ? '0 - e3mag : e3mag;
			r_s10    <= r_s9;
			vec_s10  <= vec_s9;
			coef_s10 <= coef_s9;

			de_s11   <= t2_s10 + t3_s10 + t4_s10;
			k4p4_s11 <= {k4p4h_s10, 32'd0} + {24'd0, k4p4l_s10};
			e23_s11  <= e2_s10 + e3_s10;
			r_s11    <= r_s10;
			vec_s11  <= vec_s10;
			coef_s11 <= coef_s10;

			demag_s12 <= de_s11[63] ? 64'd0 - de_s11 : de_s11;
			deneg_s12 <= de_s11[63];
			esum_s12  <= e23_s11 + (coef_s11.ks[2] ? '0 - e4mag : e4mag);
			r_s12     <= r_s11;
			vec_s12   <= vec_s11;

			for (int i = 0; i < 3; i++) begin
				fph_s13[i] <= 64'(demag_s12[63:32]) * 64'(vec_s12.mag[i]);
				fpl_s13[i] <= 64'(demag_s12[31:0]) * 64'(vec_s12.mag[i]);
			end
			late_s13 <= late_n13;
			r_s13    <= r_s12;

			for (int i = 0; i < 3; i++) begin
				n_s14[i] <= {fph_s13[i], 32'd0} + {32'd0, fpl_s13[i]};
			end
			late_s14 <= late_s13;
			r_s14    <= r_s13;

			for (int i = 0; i < 3; i++) begin
				ovf_s15[i] <= n_s14[i][95:44] >= {20'd0, r_s14};
				rem_s15[i] <= n_s14[i][75:44];
				lo_s15[i]  <= {n_s14[i][43:0], 4'b0000};
			end
			late_s15 <= late_s14;
		end
	end

	// Division of the force numerators by r, one quotient bit per stage.
	logic       dv_v_s    [DV_N];
	logic [2:0] dv_ovf_s  [DV_N];
	logic [2:0][31:0] dv_rem_s [DV_N];
	logic [2:0][47:0] dv_lo_s  [DV_N];
	logic [2:0][47:0] dv_q_s   [DV_N];
	qbf_pkg::late_t   dv_late_s [DV_N];

	for (genvar j = 0; j < DV_N; j++) begin : g_div
		logic v_i;
		logic [2:0] ovf_i;
		logic [2:0][31:0] rem_i;
		logic [2:0][47:0] lo_i, q_i;
		qbf_pkg::late_t late_i;
		logic [2:0][32:0] t;
		logic [2:0] ge;

		if (j == 0) begin : g_first
			assign v_i    = v_s15;
			assign ovf_i  = ovf_s15;
			assign rem_i  = rem_s15;
			assign lo_i   = lo_s15;
			assign q_i    = '0;
			assign late_i = late_s15;
		end else begin : g_next
			assign v_i    = dv_v_s[j-1];
			assign ovf_i  = dv_ovf_s[j-1];
			assign rem_i  = dv_rem_s[j-1];
			assign lo_i   = dv_lo_s[j-1];
			assign q_i    = dv_q_s[j-1];
			assign late_i = dv_late_s[j-1];
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				t[i]  = {rem_i[i], lo_i[i][47]};
				ge[i] = t[i] >= {1'b0, late_i.r};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j] <= 1'b0;
			end else if (en) begin
				dv_v_s[j] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					dv_rem_s[j][i] <= ge[i] ? 32'(t[i] - {1'b0, late_i.r}) : t[i][31:0];
					dv_q_s[j][i]   <= {q_i[i][46:0], ge[i]};
					dv_lo_s[j][i]  <= {lo_i[i][46:0], 1'b0};
				end
				dv_ovf_s[j]  <= ovf_i;
				dv_late_s[j] <= late_i;
			end
		end
	end

	// Sign, saturation and zero-length handling of the finished item.
	qbf_pkg::late_t lt;
	qbf_pkg::res_t fin;
	logic [2:0] fneg, fover;
	logic [2:0][47:0] flim, fmag;

	assign lt = dv_late_s[DV_N-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fneg[i]  = (lt.deneg == lt.dneg[i]);
			flim[i]  = fneg[i] ? qbf_pkg::FORCE_NEG_LIM : qbf_pkg::FORCE_POS_LIM;
			fover[i] = (lt.r != '0) &&
				(dv_ovf_s[DV_N-1][i] || (dv_q_s[DV_N-1][i] > flim[i]));
			fmag[i]  = fover[i] ? flim[i] : dv_q_s[DV_N-1][i];
			if (lt.r == '0) begin
				fin.force_v[i] = '0;
			end else begin
				fin.force_v[i] = fneg[i] ? 48'd0 - fmag[i] : fmag[i];
			end
		end
		fin.energy = lt.energy;
		fin.sat    = lt.esat | (|fover);
	end

	// Output register with one skid entry.
	qbf_pkg::res_t out_q, skid_q;
	logic fin_v;

	assign fin_v = en & dv_v_s[DV_N-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
		end else if (en) begin
			v_s1  <= accept && (kind == qbf_pkg::KIND_EVAL);
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= sr_v_s[SQ_N-1];
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && out_ready) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= fin_v;
			end
		end else if (!out_v_q) begin
			out_v_q <= fin_v;
		end else if (fin_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && out_ready) begin
			out_q <= skid_v_q ? skid_q : fin;
		end else if (!out_v_q) begin
			out_q <= fin;
		end else if (fin_v) begin
			skid_q <= fin;
		end
	end

	assign out_valid   = out_v_q;
	assign force_x     = out_q.force_v[0];
	assign force_y     = out_q.force_v[1];
	assign force_z     = out_q.force_v[2];
	assign bond_energy = out_q.energy;
	assign saturated   = out_q.sat;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without a pending output item");

	a_sqrt_floor: assert property (@(posedge clk) disable iff (!arst_n)
		sr_v_s[SQ_N-1] |-> (sr_rem_s[SQ_N-1] <= {1'b0, sr_res_s[SQ_N-1], 1'b0}))
		else $error("square root remainder exceeds twice the root");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_v_s[DV_N-1] && lt.r != '0 && dv_ovf_s[DV_N-1] == 3'b000) |->
		(dv_rem_s[DV_N-1][0] < lt.r && dv_rem_s[DV_N-1][1] < lt.r &&
		dv_rem_s[DV_N-1][2] < lt.r))
		else $error("division remainder not below the divisor");

	a_skid_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_ready && fin_v) |=> (skid_v_q && !in_ready))
		else $error("result arriving at a held output was not parked");

endmodule

### sim/qbf_checker.sv
// Checker for the quartic bond force pipeline: predicts every evaluate item and compares results.
// Depends on qbf_pkg for the item kinds; watches the ports of quartic_bond_force.
`timescale 1ns / 100ps
module qbf_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               kind,
	input  logic [3:0]         bond_type,
	input  logic signed [31:0] delta_x,
	input  logic signed [31:0] delta_y,
	input  logic signed [31:0] delta_z,
	input  logic               want_energy,
	input  logic [30:0]        rest_length_in,
	input  logic signed [31:0] quad_coeff_in,
	input  logic signed [31:0] cubic_coeff_in,
	input  logic signed [31:0] quartic_coeff_in,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [47:0] force_x,
	input  logic signed [47:0] force_y,
	input  logic signed [47:0] force_z,
	input  logic signed [63:0] bond_energy,
	input  logic               saturated,
	output int                 fails,
	output int                 pending
);

	typedef struct {
		bit [47:0] fx;
		bit [47:0] fy;
		bit [47:0] fz;
		bit [63:0] energy;
		bit        sat;
	} bond_result_t;

	bond_result_t bond_results[$];
	bit [30:0] rest_mem[16];
	bit [31:0] k2_mem[16];
	bit [31:0] k3_mem[16];
	bit [31:0] k4_mem[16];
	int fail_count = 0;

	assign fails = fail_count;
	assign pending = bond_results.size();

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic bit [63:0] magnitude(input longint v);
		bit [63:0] u;
		u = v;
		return v < 0 ? 64'd0 - u : u;
	endfunction

	function automatic bit [63:0] int_sqrt(input bit [63:0] v);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint slope_term(input bit [63:0] c, input longint k,
			input bit [63:0] p, input bit pneg);
		bit [127:0] t;
		bit [63:0] m;
		t = ({64'd0, c * magnitude(k)} * {64'd0, p}) >> 20;
		m = t[63:0];
		return ((k < 0) != pneg) ? -longint'(m) : longint'(m);
	endfunction

	function automatic bit [127:0] energy_term(input longint k, input bit [63:0] p,
			input bit pneg);
		bit [127:0] t;
		t = ({64'd0, magnitude(k)} * {64'd0, p}) >> 8;
		return ((k < 0) != pneg) ? 128'd0 - t : t;
	endfunction

	// Returns the clip flag above the 48-bit force component.
	function automatic bit [48:0] force_part(input longint de, input longint d,
			input bit [63:0] r);
		bit [127:0] q, lim;
		bit neg, clip;
		if (r == 0)
			return 49'd0;
		q = ({64'd0, magnitude(de)} * {64'd0, magnitude(d) << 4}) / {64'd0, r};
		neg = (de < 0) == (d < 0);
		lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
		clip = q > lim;
		if (clip)
			q = lim;
		if (neg)
			q = 128'd0 - q;
		return {clip, q[47:0]};
	endfunction

	function automatic bond_result_t predict_bond(input longint dx, input longint dy,
			input longint dz, input bit we, input bit [30:0] r0, input longint k2,
			input longint k3, input longint k4);
		bond_result_t res;
		bit [63:0] r, m, p2, p3, p4;
		bit [127:0] w, e;
		longint dr, de;
		bit drneg;
		bit [48:0] fp;
		r = int_sqrt(magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy)
			+ magnitude(dz) * magnitude(dz));
		dr = longint'(r) - longint'({33'd0, r0});
		drneg = dr < 0;
		m = magnitude(dr);
		w = ({64'd0, m} * {64'd0, m}) >> 24;
		p2 = w[63:0];
		w = ({64'd0, p2} * {64'd0, m}) >> 24;
		p3 = w[63:0];
		w = ({64'd0, p3} * {64'd0, m}) >> 24;
		p4 = w[63:0];
		de = slope_term(2, k2, m, drneg) + slope_term(3, k3, p2, 1'b0)
			+ slope_term(4, k4, p3, drneg);
		res.sat = 0;
		fp = force_part(de, dx, r);
		res.fx = fp[47:0];
		res.sat |= fp[48];
		fp = force_part(de, dy, r);
		res.fy = fp[47:0];
		res.sat |= fp[48];
		fp = force_part(de, dz, r);
		res.fz = fp[47:0];
		res.sat |= fp[48];
		res.energy = 0;
		if (we) begin
			e = energy_term(k2, p2, 1'b0) + energy_term(k3, p3, drneg)
				+ energy_term(k4, p4, 1'b0);
			if (e[127:63] != {65{e[63]}}) begin
				res.energy = e[127] ? qbf_pkg::ENERGY_MIN : qbf_pkg::ENERGY_MAX;
				res.sat = 1;
			end else begin
				res.energy = e[63:0];
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bond_result_t want;
		if (!arst_n) begin
			bond_results.delete();
		end else begin
			if (in_valid && in_ready) begin
				if (kind == qbf_pkg::KIND_LOAD) begin
					rest_mem[bond_type] <= rest_length_in;
					k2_mem[bond_type] <= quad_coeff_in;
					k3_mem[bond_type] <= cubic_coeff_in;
					k4_mem[bond_type] <= quartic_coeff_in;
				end else begin
					bond_results.push_back(predict_bond(delta_x, delta_y, delta_z,
						want_energy, rest_mem[bond_type],
						longint'($signed(k2_mem[bond_type])),
						longint'($signed(k3_mem[bond_type])),
						longint'($signed(k4_mem[bond_type]))));
				end
			end
			if (out_valid && out_ready) begin
				if (bond_results.size() == 0) begin
					report("result with no item waiting");
				end else begin
					want = bond_results.pop_front();
					if (force_x !== want.fx)
						report($sformatf("force_x %h, expected %h", force_x, want.fx));
					if (force_y !== want.fy)
						report($sformatf("force_y %h, expected %h", force_y, want.fy));
					if (force_z !== want.fz)
						report($sformatf("force_z %h, expected %h", force_z, want.fz));
					if (bond_energy !== want.energy)
						report($sformatf("bond_energy %h, expected %h", bond_energy,
							want.energy));
					if (saturated !== want.sat)
						report($sformatf("saturated %b, expected %b", saturated, want.sat));
				end
			end
		end
	end

endmodule

### sim/quartic_bond_force_test.sv
// Testbench top for quartic_bond_force: drives load and evaluate items, stalls the output.
// Depends on qbf_pkg, design/quartic_bond_force.sv and sim/qbf_checker.sv.
`timescale 1ns / 100ps
module quartic_bond_force_test;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid, in_ready, kind, want_energy, out_valid, out_ready, saturated;
	logic [3:0] bond_type;
	logic signed [31:0] delta_x, delta_y, delta_z;
	logic [30:0] rest_length_in;
	logic signed [31:0] quad_coeff_in, cubic_coeff_in, quartic_coeff_in;
	logic signed [47:0] force_x, force_y, force_z;
	logic signed [63:0] bond_energy;
	int fails, pending;
	int cycles = 0;
	bit long_hold = 0;
	bit steady = 0;
	bit [30:0] rest_of[16];

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	quartic_bond_force i_dut (.*);
	qbf_checker i_checker (.*);

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
	endfunction

	task automatic send(input logic k, input logic [3:0] t, input logic [31:0] dx,
			input logic [31:0] dy, input logic [31:0] dz, input logic we,
			input logic [30:0] r0, input logic [31:0] k2, input logic [31:0] k3,
			input logic [31:0] k4, input int gap);
		in_valid <= 1;
		kind <= k;
		bond_type <= t;
		delta_x <= dx;
		delta_y <= dy;
		delta_z <= dz;
		want_energy <= we;
		rest_length_in <= r0;
		quad_coeff_in <= k2;
		cubic_coeff_in <= k3;
		quartic_coeff_in <= k4;
		if (k == qbf_pkg::KIND_LOAD)
			rest_of[t] = r0;
		do
			@(posedge clk);
		while (!in_ready);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] near_len();
		return $urandom_range(0, 32'h0600_0000) - 32'h0300_0000;
	endfunction

	function automatic logic [31:0] near_coeff();
		return $urandom_range(0, 200 << 16) - (100 << 16);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int stall;
		int hold_cycles;
		bit held;
		out_ready <= 0;
		stall = 0;
		hold_cycles = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold && !held) begin
				held = 1;
				hold_cycles = 400;
			end
			if (hold_cycles > 0) begin
				out_ready <= 0;
				hold_cycles--;
			end else if (stall > 0 && !steady) begin
				out_ready <= 0;
				stall--;
			end else begin
				out_ready <= 1;
				if ($urandom_range(0, 3) == 0)
					stall = gap_len();
			end
		end
	end

	initial begin
		logic [3:0] t;
		logic [31:0] dx, dy, dz;
		in_valid <= 0;
		kind <= qbf_pkg::KIND_EVAL;
		bond_type <= 0;
		delta_x <= 0;
		delta_y <= 0;
		delta_z <= 0;
		want_energy <= 0;
		rest_length_in <= 0;
		quad_coeff_in <= 0;
		cubic_coeff_in <= 0;
		quartic_coeff_in <= 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(qbf_pkg::KIND_LOAD, 0, 0, 0, 0, 0, 31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 0);
		send(qbf_pkg::KIND_LOAD, 15, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 1);
		for (int i = 1; i < 15; i++)
			send(qbf_pkg::KIND_LOAD, 4'(i), $urandom, $urandom, $urandom, 1,
				31'($urandom_range(1 << 24, 3 << 24)), near_coeff(), near_coeff(),
				near_coeff(), 0);
		send(qbf_pkg::KIND_EVAL, 3, 0, 0, 0, 1, 0, 0, 0, 0, 0);
		send(qbf_pkg::KIND_EVAL, 15, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 0, 0,
			0, 0);
		send(qbf_pkg::KIND_EVAL, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0, 0, 0,
			0, 2);
		send(qbf_pkg::KIND_EVAL, 15, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
		send(qbf_pkg::KIND_EVAL, 0, 1, 0, 0, 1, 0, 0, 0, 0, 0);
		send(qbf_pkg::KIND_EVAL, 5, {1'b0, rest_of[5]}, 0, 0, 1, 0, 0, 0, 0, 0);
		send(qbf_pkg::KIND_EVAL, 7, 32'h0100_0000, 32'hFF00_0000, 32'h0080_0000, 0, 0, 0, 0,
			0, 3);
		send(qbf_pkg::KIND_EVAL, 7, 32'h0100_0000, 32'hFF00_0000, 32'h0080_0000, 1, 0, 0, 0,
			0, 0);

		for (int n = 0; n < 700; n++) begin
			if (n == 200)
				long_hold = 1;
			if (n == 450) begin
				in_valid <= 0;
				do
					@(posedge clk);
				while (pending != 0);
				repeat (120) @(posedge clk);
			end
			steady = (n >= 520 && n < 620);
			t = 4'($urandom_range(0, 15));
			if ($urandom_range(0, 5) == 0) begin
				if ($urandom_range(0, 7) == 0)
					send(qbf_pkg::KIND_LOAD, t, $urandom, $urandom, $urandom, 1'($urandom),
						31'($urandom), $urandom, $urandom, $urandom,
						(steady || (n >= 200 && n < 260)) ? 0 : gap_len());
				else
					send(qbf_pkg::KIND_LOAD, t, $urandom, $urandom, $urandom, 1'($urandom),
						31'($urandom_range(1 << 24, 3 << 24)), near_coeff(), near_coeff(),
						near_coeff(), (steady || (n >= 200 && n < 260)) ? 0 : gap_len());
			end else begin
				case ($urandom_range(0, 19)) inside
					0: begin
						dx = 0;
						dy = 0;
						dz = 0;
					end
					1: begin
						dx = {1'b0, rest_of[t]};
						dy = 0;
						dz = 0;
					end
					[2:3]: begin
						dx = $urandom;
						dy = $urandom;
						dz = $urandom;
					end
					default: begin
						dx = near_len();
						dy = near_len();
						dz = near_len();
					end
				endcase
				send(qbf_pkg::KIND_EVAL, t, dx, dy, dz, 1'($urandom), 31'($urandom),
					$urandom, $urandom, $urandom,
					(steady || (n >= 200 && n < 260)) ? 0 : gap_len());
			end
		end
		in_valid <= 0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (120) @(posedge clk);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
